// File: rtl/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

   // Table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int RANK_W  = IDX_W;
   localparam int COUNT_W = IDX_W + 1;

   // Item fields
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int KV_W    = KEY_W + VALUE_W;

   // Capacity register
   localparam int             CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Answer of a get that misses
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // Update request from the sequencer to the recency tracker
   typedef struct packed {
      logic             touch;    // get hit: move entry to front
      logic             put;      // put: remove old copy, evict, insert
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
   } rec_cmd_type;

   // Status from the recency tracker
   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [IDX_W-1:0]   free_idx; // slot a put writes into
   } rec_stat_type;

endpackage

// File: rtl/lkvc_req_if.sv
// Request channel of the cache: op, key and value with valid/ready.
interface lkvc_req_if
   import lkvc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   op_type                    op;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, op, key, value, input ready);
   modport sink   (input valid, op, key, value, output ready);
endinterface

// File: rtl/lkvc_rsp_if.sv
// Response channel of the cache: found flag and read value with valid/ready.
interface lkvc_rsp_if
   import lkvc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink   (input valid, found, read_value, output ready);
endinterface

// File: rtl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: scan sequencer, capacity register, response register.
//
// Usage:
//   req  - sink of get/put items (op, key, value); taken when valid and ready are high.
//   rsp  - source of one result per item (found, read_value), held until ready.
//   csr_wr_en / csr_wr_data - write the capacity register (1..16 entries in use;
//          0 acts as 1, above 16 acts as 16). Write only while the block is idle.
// Operation:
//   An item scans the key/value RAM one entry a cycle through its single read
//   port: 16 reads, each compared when its registered read data returns, then
//   an update cycle that writes the RAM, adjusts the ranks and loads the
//   response register. A new item is taken only once the previous item's
//   update is done and the block is back in idle.
//   The RAM is written only in the update cycle, so no read overlaps a write.
// Reset:
//   Clears all valid marks, the live count and the response valid flag; capacity
//   returns to 16. Key, value and rank storage is not cleared.
// Back-pressure:
//   A new item is taken while a result still waits; its update cycle then
//   holds until the response register is free.
module lru_key_value_cache_core
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lkvc_req_if.sink         req_chan,
   lkvc_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]          capacity_ff;
   op_type                    op_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issued_ff, issued_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic signed [VALUE_W-1:0] hit_val_ff, hit_val_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff;
   logic signed [VALUE_W-1:0] read_value_ff;

   logic                 accept;
   logic                 rd_en;
   logic [KV_W-1:0]      rd_data;
   logic [KEY_W-1:0]     rd_key;
   logic [VALUE_W-1:0]   rd_value;
   logic                 out_free;
   logic                 do_update;
   rec_cmd_type          cmd;
   rec_stat_type         stat;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rd_key   = rd_data[KV_W-1 -: KEY_W];
   assign rd_value = rd_data[VALUE_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      issued_in  = issued_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = rd_idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_val_in = hit_val_ff;
      rd_en      = 1'b0;
      do_update  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_SCAN;
               addr_in   = '0;
               issued_in = 1'b0;
               hit_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the one that returns
            if (!issued_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = addr_ff;
               addr_in    = addr_ff + IDX_W'(1);
               issued_in  = (addr_ff == IDX_W'(ENTRIES - 1));
            end
            if (rd_pend_ff && stat.valid[rd_idx_ff] && rd_key == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               hit_val_in = rd_value;
            end
            if (rd_pend_ff && rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               do_update = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Recency update request
   assign cmd.touch   = do_update && (op_ff == OP_GET) && hit_ff;
   assign cmd.put     = do_update && (op_ff == OP_PUT);
   assign cmd.hit     = hit_ff;
   assign cmd.hit_idx = hit_idx_ff;

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (do_update) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         found_ff <= hit_ff;
         if (op_ff == OP_PUT) begin
            read_value_ff <= value_ff;
         end else if (hit_ff) begin
            read_value_ff <= hit_val_ff;
         end else begin
            read_value_ff <= MISS_VALUE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Item and scan registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_chan.op;
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      addr_ff    <= addr_in;
      issued_ff  <= issued_in;
      rd_idx_ff  <= rd_idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_val_ff <= hit_val_in;
   end

   lkvc_kv_ram #(
      .DATA_W (KV_W),
      .DEPTH  (ENTRIES)
   ) u_kv_ram (
      .clock   (clock),
      .wr_en   (cmd.put),
      .wr_addr (stat.free_idx),
      .wr_data ({key_ff, value_ff}),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   lkvc_recency u_recency (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .cmd      (cmd),
      .stat     (stat)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.read_value = read_value_ff;

endmodule

// File: rtl/lkvc_kv_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module lkvc_kv_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lkvc_recency.sv
// Per-entry valid marks, recency ranks and live count, with the LRU update.
module lkvc_recency
   import lkvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CAP_W-1:0]   capacity,
   input  rec_cmd_type        cmd,
   output rec_stat_type       stat
);

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_in [ENTRIES];
   logic [COUNT_W-1:0] live_ff, live_in;

   logic [COUNT_W-1:0] cap_eff;
   logic [COUNT_W-1:0] cap_m1;
   logic [RANK_W-1:0]  hit_rank;
   logic [ENTRIES-1:0] keep;
   logic [RANK_W-1:0]  r_dec [ENTRIES];
   logic [IDX_W-1:0]   free_idx;
   logic [COUNT_W-1:0] live_left;

   // Capacity clamped to 1..ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (int'(capacity) > ENTRIES) begin
         cap_eff = COUNT_W'(ENTRIES);
      end else begin
         cap_eff = COUNT_W'(capacity);
      end
   end

   assign cap_m1   = cap_eff - COUNT_W'(1);
   assign hit_rank = rank_ff[cmd.hit_idx];

   // Put: drop the old copy, close its gap, evict ranks of capacity-1 and above
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         r_dec[i] = (cmd.hit && rank_ff[i] > hit_rank) ? rank_ff[i] - RANK_W'(1)
                                                        : rank_ff[i];
         keep[i]  = valid_ff[i] && !(cmd.hit && cmd.hit_idx == IDX_W'(i)) &&
                    (COUNT_W'(r_dec[i]) < cap_m1);
      end
   end

   // Lowest slot left free after the put's removals
   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!keep[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign live_left = live_ff - COUNT_W'(cmd.hit);

   // Next state of marks, ranks and count
   always_comb begin
      valid_in = valid_ff;
      live_in  = live_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (cmd.hit_idx == IDX_W'(i)) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end else if (cmd.put) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_in[i] = keep[i];
            rank_in[i]  = r_dec[i] + RANK_W'(1);
         end
         valid_in[free_idx] = 1'b1;
         rank_in[free_idx]  = '0;
         live_in = ((live_left < cap_m1) ? live_left : cap_m1) + COUNT_W'(1);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
      end
   end

   // Ranks only mean something where the valid mark is set
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

   assign stat.valid    = valid_ff;
   assign stat.free_idx = free_idx;

endmodule

// File: sim/testbench.sv
// Self-checking testbench of the LRU key-value cache core: predictor, scoreboard and drivers.
module testbench
   import lkvc_pkg::*;
();

   // Expected answer of one item
   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  read_value;
   } answer_type;

   // Recency-ranked copy of the table; predicts each answer and checks results in order
   class lru_scoreboard;
      logic [KEY_W-1:0]   keys [ENTRIES];
      logic [VALUE_W-1:0] values [ENTRIES];
      bit                 live [ENTRIES];
      int unsigned        rank [ENTRIES];
      int unsigned        occupancy;
      logic [CAP_W-1:0]   capacity;
      answer_type         answers [$];
      int                 mismatches;
      int                 checked;
      int                 found_count;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         occupancy   = 0;
         capacity    = CAP_RESET;
         mismatches  = 0;
         checked     = 0;
         found_count = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      // Zero acts as one, anything over the table size as the table size
      function int unsigned limit();
         int unsigned c;
         c = capacity;
         if (c == 0) c = 1;
         if (c > ENTRIES) c = ENTRIES;
         return c;
      endfunction

      function int lookup(logic [KEY_W-1:0] key);
         for (int i = 0; i < ENTRIES; i++)
            if (live[i] && keys[i] == key) return i;
         return -1;
      endfunction

      // Drop an entry and close the gap behind it in the ranking
      function void drop(int s);
         int unsigned r;
         r = rank[s];
         live[s] = 1'b0;
         for (int i = 0; i < ENTRIES; i++)
            if (live[i] && rank[i] > r) rank[i]--;
         if (occupancy > 0) occupancy--;
      endfunction

      function void promote(int s);
         int unsigned r;
         r = rank[s];
         for (int i = 0; i < ENTRIES; i++)
            if (i != s && live[i] && rank[i] < r) rank[i]++;
         rank[s] = 0;
      endfunction

      function int oldest();
         int best;
         best = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (live[i] && (best < 0 || rank[i] > rank[best])) best = i;
         return best;
      endfunction

      function int outstanding();
         return answers.size();
      endfunction

      // Work out the answer of an accepted item and update the table copy
      function void note_request(op_type op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
         int         hit;
         int         slot;
         int         victim;
         answer_type ans;
         hit = lookup(key);
         if (op == OP_GET) begin
            if (hit >= 0) begin
               promote(hit);
               ans.found      = 1'b1;
               ans.read_value = values[hit];
            end else begin
               ans.found      = 1'b0;
               ans.read_value = MISS_VALUE;
            end
         end else begin
            ans.found      = (hit >= 0);
            ans.read_value = value;
            if (hit >= 0) drop(hit);
            // evict until there is room, also after the capacity was lowered
            while (occupancy >= limit()) begin
               victim = oldest();
               if (victim < 0) begin
                  occupancy = 0;
                  break;
               end
               drop(victim);
            end
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (!live[i] && slot < 0) slot = i;
            if (slot < 0) begin
               slot = oldest();
               if (slot < 0) slot = 0;
               else drop(slot);
            end
            for (int i = 0; i < ENTRIES; i++)
               if (live[i]) rank[i]++;
            keys[slot]   = key;
            values[slot] = value;
            rank[slot]   = 0;
            live[slot]   = 1'b1;
            occupancy++;
         end
         answers.push_back(ans);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH: %s", what);
      endtask

      // Compare one accepted result with the oldest expected answer
      task check_response(logic found, logic [VALUE_W-1:0] read_value);
         answer_type ans;
         if (answers.size() == 0) begin
            report_mismatch($sformatf("result found=%0b value=%h with nothing outstanding",
                                      found, read_value));
         end else begin
            ans = answers.pop_front();
            checked++;
            if (found) found_count++;
            if (found !== ans.found)
               report_mismatch($sformatf("result %0d: found %0b, expected %0b",
                                         checked, found, ans.found));
            if (read_value !== ans.read_value)
               report_mismatch($sformatf("result %0d: read_value %h, expected %h",
                                         checked, read_value, ans.read_value));
         end
      endtask
   endclass

   localparam int NUM_PHASES = 8;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE     = 20;

   // Per phase: capacity written, sender idle and receiver stall in percent, items
   int phase_cap   [NUM_PHASES] = '{16, 3, 31, 0, 17, 8, 1, 5};
   int phase_idle  [NUM_PHASES] = '{0, 68, 0, 28, 0, 68, 0, 28};
   int phase_stall [NUM_PHASES] = '{0, 0, 68, 28, 0, 0, 68, 28};
   int phase_items [NUM_PHASES] = '{300, 250, 250, 200, 250, 250, 200, 300};

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   lru_scoreboard sb = new();

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_calls    = 0;
   int items_sent    = 0;
   int cap_writes    = 0;
   logic [KEY_W-1:0] key_pool [20];

   lru_key_value_cache_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item after a random idle gap; return once it is taken
   task automatic send_item(op_type op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      req_bus.value <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_request(op, key, value);
      items_sent++;
   endtask

   // Stop offering and wait until every expected result is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_capacity(cap);
      cap_writes++;
   endtask

   // Mostly keys from a small pool so hits and evictions happen; some fresh keys
   task automatic random_item(int pool_n);
      logic [KEY_W-1:0] key;
      op_type           op;
      if ($urandom_range(99) < 15) key = $urandom;
      else key = key_pool[$urandom_range(pool_n - 1)];
      op = ($urandom_range(99) < 55) ? OP_PUT : OP_GET;
      send_item(op, key, $urandom);
   endtask

   // Result side: checks every accepted item, stalls at random and on request
   initial begin : result_sink
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.found, rsp_bus.read_value);
         if (hold_calls != holds_seen) begin
            holds_seen = hold_calls;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Stimulus: reset, directed items, then random phases at several capacities
   initial begin : stimulus
      int pool_n;
      int eff;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      req_bus.valid <= 1'b0;
      req_bus.op    <= OP_GET;
      req_bus.key   <= '0;
      req_bus.value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_capacity(CAP_W'(16));

      // directed: empty table, field extremes, update of an existing key, miss
      send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_PUT, 32'h8000_0000, 32'h0000_04D2);
      send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_3039, 32'h0000_0000);
      drain();

      // directed: capacity lowered below the live count, then eviction order
      write_capacity(CAP_W'(2));
      send_item(OP_PUT, 32'h0000_000A, 32'h0000_0001);
      send_item(OP_PUT, 32'h0000_000B, 32'h0000_0002);
      send_item(OP_GET, 32'h0000_000A, 32'h0000_0000);
      send_item(OP_PUT, 32'h0000_000C, 32'h0000_0003);
      send_item(OP_GET, 32'h0000_000B, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_000A, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_000C, 32'h0000_0000);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(CAP_W'(phase_cap[p]));
         send_idle_pct = phase_idle[p];
         stall_pct    <= phase_stall[p];
         eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > ENTRIES ? ENTRIES : phase_cap[p]);
         pool_n = (eff + 3 > 20) ? 20 : eff + 3;
         foreach (key_pool[i]) key_pool[i] = $urandom;
         for (int n = 0; n < phase_items[p]; n++) begin
            // receiver holds off for a long stretch while items keep coming
            if (p == 2 && n == 40) hold_calls <= hold_calls + 1;
            // sender waits for every outstanding result once
            if (p == 4 && n == 120) drain();
            random_item(pool_n);
         end
         drain();
      end

      stall_pct <= 0;
      repeat (40) @(posedge clock);
      $display("%0d items over %0d capacity writes; %0d results checked, %0d with key found",
               items_sent, cap_writes, sb.checked, sb.found_count);
      $display("covered idle and stalling sides, a long receiver hold-off and capacities 0 to 31");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
